// ===== rtl/core/qrm_pkg.sv =====
// Shared constants for the quaternion to rotation matrix unit.
// No dependencies.
package qrm_pkg;

  localparam int NUM_ENTRIES = 9;

  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

endpackage

// ===== rtl/core/quaternion_to_rotation_matrix_unit.sv =====
// Quaternion to normalized 3x3 rotation matrix, pipelined.
// Depends on qrm_pkg.
//
// channel  dir  handshake          payload
// q        in   q_valid / q_stall  qw qx qy qz
// m        out  m_valid / m_stall  m00..m22 zero_norm
//
// One item per cycle while m_stall is low. Stages: product, sum,
// magnitude, FRACTION_BITS+2 restoring divide stages (one quotient bit per
// stage, nine lanes) and an output stage. Synchronous reset clears valid bits.
// Each stage holds while the next is full and stalled; bubbles collapse.
module quaternion_to_rotation_matrix_unit
  import qrm_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] qw,
  input  logic signed [COMPONENT_WIDTH-1:0] qx,
  input  logic signed [COMPONENT_WIDTH-1:0] qy,
  input  logic signed [COMPONENT_WIDTH-1:0] qz,
  output logic                              m_valid,
  input  logic                              m_stall,
  output logic signed [COMPONENT_WIDTH-1:0] m00,
  output logic signed [COMPONENT_WIDTH-1:0] m01,
  output logic signed [COMPONENT_WIDTH-1:0] m02,
  output logic signed [COMPONENT_WIDTH-1:0] m10,
  output logic signed [COMPONENT_WIDTH-1:0] m11,
  output logic signed [COMPONENT_WIDTH-1:0] m12,
  output logic signed [COMPONENT_WIDTH-1:0] m20,
  output logic signed [COMPONENT_WIDTH-1:0] m21,
  output logic signed [COMPONENT_WIDTH-1:0] m22,
  output logic                              zero_norm
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;
  localparam int QW = FRACTION_BITS + 2;
  localparam int NS = QW + 4;
  localparam int LAST = NS - 1;
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[LAST] = !vld[LAST] || !m_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign q_stall = !en[0];
  assign m_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= q_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // products
  logic signed [PW-1:0] pww, pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
  logic                 pzero;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pww   <= PW'(qw) * PW'(qw);
      pxx   <= PW'(qx) * PW'(qx);
      pyy   <= PW'(qy) * PW'(qy);
      pzz   <= PW'(qz) * PW'(qz);
      pxy   <= PW'(qx) * PW'(qy);
      pxz   <= PW'(qx) * PW'(qz);
      pyz   <= PW'(qy) * PW'(qz);
      pxw   <= PW'(qx) * PW'(qw);
      pyw   <= PW'(qy) * PW'(qw);
      pzw   <= PW'(qz) * PW'(qw);
      pzero <= (qw == '0) && (qx == '0) && (qy == '0) && (qz == '0);
    end
  end

  // signed numerators and norm
  logic signed [DW-1:0] sww, sxx, syy, szz, sxy, sxz, syz, sxw, syw, szw;
  logic signed [DW-1:0] snum [NUM_ENTRIES];
  logic        [DW-1:0] sn2;
  logic                 szero;

  assign sww = DW'(pww);
  assign sxx = DW'(pxx);
  assign syy = DW'(pyy);
  assign szz = DW'(pzz);
  assign sxy = DW'(pxy);
  assign sxz = DW'(pxz);
  assign syz = DW'(pyz);
  assign sxw = DW'(pxw);
  assign syw = DW'(pyw);
  assign szw = DW'(pzw);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      snum[E00] <= sww + sxx - syy - szz;
      snum[E11] <= sww - sxx + syy - szz;
      snum[E22] <= sww - sxx - syy + szz;
      snum[E01] <= (sxy - szw) <<< 1;
      snum[E10] <= (sxy + szw) <<< 1;
      snum[E02] <= (sxz + syw) <<< 1;
      snum[E20] <= (sxz - syw) <<< 1;
      snum[E12] <= (syz - sxw) <<< 1;
      snum[E21] <= (syz + sxw) <<< 1;
      sn2       <= sww + sxx + syy + szz;
      szero     <= pzero;
    end
  end

  // divide pipeline; index 0 is the magnitude stage
  logic [DW-1:0] dr   [QW+1][NUM_ENTRIES];
  logic [QW-1:0] dq   [QW+1][NUM_ENTRIES];
  logic          dneg [QW+1][NUM_ENTRIES];
  logic [DW-1:0] dd   [QW+1];
  logic          dz   [QW+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        dneg[0][e] <= snum[e][DW-1];
        dr[0][e]   <= snum[e][DW-1] ? DW'(-snum[e]) : DW'(snum[e]);
        dq[0][e]   <= '0;
      end
      dd[0] <= sn2;
      dz[0] <= szero;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          if (dr[k][e] >= dd[k]) begin
            dr[k+1][e] <= (dr[k][e] - dd[k]) << 1;
            dq[k+1][e] <= {dq[k][e][QW-2:0], 1'b1};
          end else begin
            dr[k+1][e] <= dr[k][e] << 1;
            dq[k+1][e] <= {dq[k][e][QW-2:0], 1'b0};
          end
          dneg[k+1][e] <= dneg[k][e];
        end
        dd[k+1] <= dd[k];
        dz[k+1] <= dz[k];
      end
    end
  end

  // round half away, apply sign, zero quaternion gives identity
  logic [QW-1:0]        rnd [NUM_ENTRIES];
  logic [W+QW-1:0]      rext [NUM_ENTRIES];
  logic signed [W-1:0]  o   [NUM_ENTRIES];
  logic                 oz;

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      rnd[e]  = (dq[QW][e] + QW'(1)) >> 1;
      rext[e] = dneg[QW][e] ? (W+QW)'(-(W+QW)'(rnd[e])) : (W+QW)'(rnd[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        if (dz[QW]) begin
          o[e] <= (e == E00 || e == E11 || e == E22) ? ONE : '0;
        end else begin
          o[e] <= rext[e][W-1:0];
        end
      end
      oz <= dz[QW];
    end
  end

  assign m00 = o[E00];
  assign m01 = o[E01];
  assign m02 = o[E02];
  assign m10 = o[E10];
  assign m11 = o[E11];
  assign m12 = o[E12];
  assign m20 = o[E20];
  assign m21 = o[E21];
  assign m22 = o[E22];
  assign zero_norm = oz;

endmodule
